FILE: rtl/integer_to_ascii_formatter_assert.svh
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter assertion macros
// concurrent assertion wrappers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

`ifndef SYNTHESIS
`define IAF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define IAF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IAF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define IAF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/iaf_pkg.sv
// ----------------------------------------------------------------------------
// iaf_pkg
// shared types, codes and the digit glyph table of the ascii formatter
// ----------------------------------------------------------------------------
`default_nettype none

package iaf_pkg;

    localparam logic [1:0] OP_DECIMAL = 2'd0;
    localparam logic [1:0] OP_HEX     = 2'd1;
    localparam logic [1:0] OP_BINARY  = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int DIGITS      = 10;
    localparam int DIGIT_AW    = 4;
    localparam int HEX_DIGITS  = 8;
    localparam int BIN_DIGITS  = 8;
    localparam int CONV_BITS   = 4;
    localparam int CONV_STEPS  = 8;
    localparam int CONV_CW     = 3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] value;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_beat;

    function automatic logic [7:0] digit_glyph(input logic [3:0] nib);
        logic [7:0] g;
        case (nib)
            4'h0: g = 8'h30;
            4'h1: g = 8'h31;
            4'h2: g = 8'h32;
            4'h3: g = 8'h33;
            4'h4: g = 8'h34;
            4'h5: g = 8'h35;
            4'h6: g = 8'h36;
            4'h7: g = 8'h37;
            4'h8: g = 8'h38;
            4'h9: g = 8'h39;
            4'hA: g = 8'h41;
            4'hB: g = 8'h42;
            4'hC: g = 8'h43;
            4'hD: g = 8'h44;
            4'hE: g = 8'h45;
            default: g = 8'h46;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/iaf_front.sv
// ----------------------------------------------------------------------------
// iaf_front
// input side: takes items, drops unused radix codes, forwards jobs
// ----------------------------------------------------------------------------
`default_nettype none

module iaf_front (
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire iaf_pkg::t_in_item i_in_item,
    input  wire logic              i_q_full,
    output iaf_pkg::t_job_beat     o_push
);
    import iaf_pkg::*;

    logic w_known;

    assign w_known = (i_in_item.operation == OP_DECIMAL) ||
                     (i_in_item.operation == OP_HEX) ||
                     (i_in_item.operation == OP_BINARY);

    assign o_in_ready       = !i_q_full;
    assign o_push.valid     = i_in_valid && !i_q_full && w_known;
    assign o_push.job.mode  = i_in_item.operation;
    assign o_push.job.value = i_in_item.value;

endmodule

`default_nettype wire

FILE: rtl/iaf_queue.sv
// ----------------------------------------------------------------------------
// iaf_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module iaf_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire iaf_pkg::t_job_beat i_push,
    output logic                    o_full,
    output iaf_pkg::t_job_beat      o_head,
    input  wire logic               i_pop
);
    import iaf_pkg::*;

    localparam logic [QUEUE_AW:0] FULL_CNT = QUEUE_AW'(QUEUE_DEPTH) == '0 ?
                                             (QUEUE_AW+1)'(QUEUE_DEPTH) :
                                             (QUEUE_AW+1)'(QUEUE_DEPTH);

    t_job                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;
    logic                w_do_pop;

    assign w_do_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QUEUE_AW+1)'(i_push.valid) - (QUEUE_AW+1)'(w_do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            mem[r_wr] <= i_push.job;
        end
    end

    assign o_full       = (r_cnt == FULL_CNT);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.job   = mem[r_rd];

endmodule

`default_nettype wire

FILE: rtl/iaf_back.sv
// ----------------------------------------------------------------------------
// iaf_back
// digit engine: bcd conversion, leading digit scan and character output
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_to_ascii_formatter_assert.svh"

module iaf_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire iaf_pkg::t_job_beat i_head,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output iaf_pkg::t_out_item      o_out_item
);
    import iaf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [DIGITS-1:0][3:0]  r_dig, n_dig;
    logic [31:0]             r_sh, n_sh;
    logic [CONV_CW-1:0]      r_cnt, n_cnt;
    logic [DIGIT_AW-1:0]     r_idx, n_idx;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out_item, n_out_item;
    logic                    w_adv;
    logic                    w_conv_end;
    logic                    w_emit_end;
    logic                    w_out_last;
    logic [DIGITS*4-1:0]     v_bcd;
    logic [31:0]             v_sh;
    logic [DIGIT_AW-1:0]     v_top;

    assign w_adv = !r_out_valid || i_out_ready;
    assign o_pop = (r_state == S_IDLE) && i_head.valid;

    assign w_conv_end = (r_state == S_CONV) && (r_cnt == CONV_CW'(CONV_STEPS - 1));
    assign w_emit_end = (r_state == S_EMIT) && w_adv && (r_idx == '0);
    assign w_out_last = r_out_valid && r_out_item.last;

    always_comb begin
        v_bcd = r_dig;
        v_sh  = r_sh;
        for (int s = 0; s < CONV_BITS; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (v_bcd[d*4 +: 4] >= 4'd5) begin
                    v_bcd[d*4 +: 4] = v_bcd[d*4 +: 4] + 4'd3;
                end
            end
            {v_bcd, v_sh} = {v_bcd[DIGITS*4-2:0], v_sh, 1'b0};
        end
    end

    always_comb begin
        v_top = '0;
        for (int d = 0; d < DIGITS; d++) begin
            if (r_dig[d] != 4'd0) begin
                v_top = DIGIT_AW'(d);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_dig       = r_dig;
        n_sh        = r_sh;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    n_dig = '0;
                    case (i_head.job.mode)
                        OP_DECIMAL: begin
                            n_sh    = i_head.job.value;
                            n_cnt   = '0;
                            n_state = S_CONV;
                        end
                        OP_HEX: begin
                            for (int d = 0; d < HEX_DIGITS; d++) begin
                                n_dig[d] = i_head.job.value[d*4 +: 4];
                            end
                            n_idx   = DIGIT_AW'(HEX_DIGITS - 1);
                            n_state = S_EMIT;
                        end
                        OP_BINARY: begin
                            for (int d = 0; d < BIN_DIGITS; d++) begin
                                n_dig[d] = {3'b000, i_head.job.value[d]};
                            end
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CONV: begin
                n_dig = v_bcd;
                n_sh  = v_sh;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CONV_CW'(CONV_STEPS - 1)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_idx   = v_top;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_adv) begin
                    n_out_valid          = 1'b1;
                    n_out_item.character = digit_glyph(r_dig[r_idx]);
                    n_out_item.last      = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig      <= n_dig;
        r_sh       <= n_sh;
        r_cnt      <= n_cnt;
        r_idx      <= n_idx;
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `IAF_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, r_state == S_EMIT, r_idx < DIGIT_AW'(DIGITS))
    `IAF_ASSERT_NXT(a_conv_done, i_clk, i_rst_n, w_conv_end, r_state == S_SCAN)
    `IAF_ASSERT_NXT(a_last_ends, i_clk, i_rst_n, w_emit_end, w_out_last && (r_state == S_IDLE))
    `IAF_ASSERT_NXT(a_pop_busy, i_clk, i_rst_n, o_pop, r_state != S_IDLE)

endmodule

`default_nettype wire

FILE: rtl/integer_to_ascii_formatter.sv
// a hex item is queued, loaded into the digit engine, then leaves as 8 characters
// decimal is loaded, converted (4 bits per cycle), scanned, then leaves as 1-10 characters
// binary is loaded, scanned, then leaves as 1-8 characters; one item in the digit engine at a time
// a two-entry job queue lets intake run ahead of the digit engine
// reset is synchronous, active low, and empties the queue and the output register
`default_nettype none

module integer_to_ascii_formatter (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire iaf_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output iaf_pkg::t_out_item     o_out_item
);
    import iaf_pkg::*;

    t_job_beat w_push;
    t_job_beat w_head;
    logic      w_full;
    logic      w_pop;

    iaf_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (w_full),
        .o_push     (w_push)
    );

    iaf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    iaf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

FILE: bench/iaf_char_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// iaf_char_scoreboard_pkg
// predicts the character beats of each accepted value and checks the
// beats leaving the formatter in order, field by field
// ----------------------------------------------------------------------------
package iaf_char_scoreboard_pkg;

    import iaf_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    class iaf_char_scoreboard;

        t_out_item expected_chars[$];
        int        mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        function logic [7:0] hex_glyph(input logic [3:0] nib);
            logic [7:0] g;
            if (nib < 4'd10) begin
                g = 8'h30 + {4'h0, nib};
            end else begin
                g = 8'h37 + {4'h0, nib};
            end
            return g;
        endfunction

        function void note_value(input t_in_item it);
            logic [31:0] rem;
            logic [7:0]  digit;
            logic [7:0]  digits[$];
            logic        started;
            t_out_item   beat;
            int          k;
            case (it.operation)
                OP_DECIMAL: begin
                    rem = it.value;
                    do begin
                        digit = 8'(32'h30 + rem % 32'd10);
                        digits.push_front(digit);
                        rem = rem / 32'd10;
                    end while (rem != 32'd0);
                end
                OP_HEX: begin
                    for (k = HEX_DIGITS - 1; k >= 0; k--) begin
                        digits.push_back(hex_glyph(it.value[4*k +: 4]));
                    end
                end
                OP_BINARY: begin
                    started = 1'b0;
                    for (k = 7; k >= 0; k--) begin
                        if (it.value[k]) begin
                            started = 1'b1;
                        end
                        if (started) begin
                            digits.push_back(it.value[k] ? 8'h31 : 8'h30);
                        end
                    end
                    if (digits.size() == 0) begin
                        digits.push_back(8'h30);
                    end
                end
                default: begin
                end
            endcase
            for (k = 0; k < digits.size(); k++) begin
                beat.character = digits[k];
                beat.last      = (k == digits.size() - 1);
                expected_chars.push_back(beat);
            end
        endfunction

        function void check_char(input t_out_item got);
            t_out_item want;
            if (expected_chars.size() == 0) begin
                $error("unexpected beat: character %h last %b", got.character, got.last);
                mismatch_count++;
                return;
            end
            want = expected_chars.pop_front();
            if (got.character !== want.character) begin
                $error("character: expected %h, actual %h", want.character, got.character);
                mismatch_count++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %b, actual %b", want.last, got.last);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

    endclass

endpackage

FILE: bench/tb_integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter
// drives values in decimal, hex and binary modes through the formatter
// with random gaps and back-pressure and checks every character beat
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter;

    timeunit 1ns;
    timeprecision 1ps;

    import iaf_pkg::*;
    import iaf_char_scoreboard_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_AT_BEAT = 150;
    localparam int HOLD_CYCLES  = 400;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    iaf_char_scoreboard sb;
    int                 cycle_count;
    int                 send_burst_left;

    integer_to_ascii_formatter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int draw_gap(inout int burst_left);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(10, 40);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 10);
        end
        return gap;
    endfunction

    function automatic logic [31:0] draw_value();
        logic [31:0] pow10[10];
        logic [31:0] v;
        int          k;
        pow10 = '{32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
                  32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000};
        case ($urandom_range(0, 4))
            0: v = $urandom_range(0, 255);
            1: begin
                k = $urandom_range(0, 9);
                v = pow10[k] + 32'($urandom_range(0, 2)) - 32'd1;
            end
            2: v = $urandom >> $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_value(input logic [1:0] op, input logic [31:0] val, input int gap);
        t_in_item it;
        it.operation = op;
        it.value     = val;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_value(it);
    endtask

    task automatic send_directed();
        send_value(OP_DECIMAL, 32'd0, draw_gap(send_burst_left));
        send_value(OP_DECIMAL, 32'd1, draw_gap(send_burst_left));
        send_value(OP_DECIMAL, 32'd9, draw_gap(send_burst_left));
        send_value(OP_DECIMAL, 32'd10, draw_gap(send_burst_left));
        send_value(OP_DECIMAL, 32'd999999999, draw_gap(send_burst_left));
        send_value(OP_DECIMAL, 32'd1000000000, draw_gap(send_burst_left));
        send_value(OP_DECIMAL, 32'hFFFFFFFF, draw_gap(send_burst_left));
        send_value(OP_HEX, 32'h00000000, draw_gap(send_burst_left));
        send_value(OP_HEX, 32'hFFFFFFFF, draw_gap(send_burst_left));
        send_value(OP_HEX, 32'h0123ABCD, draw_gap(send_burst_left));
        send_value(OP_HEX, 32'hDEADBEEF, draw_gap(send_burst_left));
        send_value(OP_HEX, 32'h456789AF, draw_gap(send_burst_left));
        send_value(OP_BINARY, 32'h00000000, draw_gap(send_burst_left));
        send_value(OP_BINARY, 32'h00000001, draw_gap(send_burst_left));
        send_value(OP_BINARY, 32'h000000FF, draw_gap(send_burst_left));
        send_value(OP_BINARY, 32'h00000080, draw_gap(send_burst_left));
        send_value(OP_BINARY, 32'hFFFFFF00, draw_gap(send_burst_left));
        send_value(OP_BINARY, 32'h12345601, draw_gap(send_burst_left));
        send_value(OP_UNUSED, 32'hFFFFFFFF, draw_gap(send_burst_left));
        send_value(OP_UNUSED, 32'h00000000, draw_gap(send_burst_left));
        send_value(OP_DECIMAL, 32'd42, 0);
        send_value(OP_UNUSED, 32'h5A5A5A5A, 0);
        send_value(OP_HEX, 32'hA5A5A5A5, 0);
    endtask

    task automatic send_random();
        int          counted;
        int          pick;
        logic [1:0]  op;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 15);
            if (pick < 5) begin
                op = OP_DECIMAL;
            end else if (pick < 10) begin
                op = OP_HEX;
            end else if (pick < 15) begin
                op = OP_BINARY;
            end else begin
                op = OP_UNUSED;
            end
            send_value(op, draw_value(), draw_gap(send_burst_left));
            if (op != OP_UNUSED) begin
                counted++;
            end
        end
    endtask

    // receiver: random stall per beat, plus one long hold-off
    initial begin
        int beats_taken;
        int burst_left;
        int stall;
        bit hold_done;
        beats_taken = 0;
        burst_left  = 0;
        hold_done   = 1'b0;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (beats_taken == HOLD_AT_BEAT && !hold_done) begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                stall = draw_gap(burst_left);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_char(o_out_item);
            beats_taken++;
        end
    end

    initial begin
        sb = new();
        send_burst_left = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_directed();
        send_random();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
